FILE: hdl/ipv4_longest_prefix_route_lookup_top_macros.svh
// Assertion helpers used by the lookup engine.
`ifndef IPV4_LONGEST_PREFIX_ROUTE_LOOKUP_TOP_MACROS_SVH
`define IPV4_LONGEST_PREFIX_ROUTE_LOOKUP_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ipv4_lpm_pkg.sv
package ipv4_lpm_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int NUM_PORTS     = 16;

  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ENTRY_INDEX_W = 4;
  localparam int PORT_W        = 4;
  localparam int ADDR_W        = 32;
  localparam int SLOT_EXT_W    = IDX_W + ENTRY_INDEX_W;
  localparam int PORT_CMP_W    = PORT_W + $clog2(NUM_PORTS + 1);

  typedef enum logic [1:0] {
    CMD_LOOKUP     = 2'd0,
    CMD_WRITE      = 2'd1,
    CMD_INVALIDATE = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [ADDR_W-1:0]        prefix;
    logic [ADDR_W-1:0]        prefix_mask;
    logic [PORT_W-1:0]        out_port;
    logic [ADDR_W-1:0]        lookup_addr;
  } item_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] prefix;
  } route_t;

  typedef struct packed {
    logic                     hit;
    logic [ENTRY_INDEX_W-1:0] match_index;
    logic [PORT_W-1:0]        match_port;
    logic [ADDR_W-1:0]        match_mask;
  } result_t;

endpackage

FILE: hdl/ipv4_lpm_ram.sv
module ipv4_lpm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 68,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/ipv4_lpm_engine.sv
`include "ipv4_longest_prefix_route_lookup_top_macros.svh"

module ipv4_lpm_engine
  import ipv4_lpm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_LAST = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic                     eval_vld_r, eval_vld_nxt;
  logic [IDX_W-1:0]         eval_idx_r, eval_idx_nxt;
  logic [ADDR_W-1:0]        addr_r, addr_nxt;
  logic                     best_hit_r, best_hit_nxt;
  logic [IDX_W-1:0]         best_idx_r, best_idx_nxt;
  logic [PORT_W-1:0]        best_port_r, best_port_nxt;
  logic [ADDR_W-1:0]        best_mask_r, best_mask_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  logic                     accept;
  logic [IDX_W-1:0]         slot;
  logic                     slot_ok;
  logic                     port_ok;
  logic                     ram_we;
  route_t                   ram_wdata;
  route_t                   ram_rdata;
  logic                     take;
  logic [SLOT_EXT_W-1:0]    slot_ext;
  logic [SLOT_EXT_W-1:0]    best_idx_ext;

  assign accept   = item_valid && item_ready;
  assign slot_ext = {{IDX_W{1'b0}}, item.entry_index};
  assign slot     = slot_ext[IDX_W-1:0];
  assign slot_ok  = slot_ext < SLOT_EXT_W'(TABLE_ENTRIES);
  assign port_ok  = {{(PORT_CMP_W-PORT_W){1'b0}}, item.out_port} < PORT_CMP_W'(NUM_PORTS);
  assign ram_we   = accept && (item.cmd == CMD_WRITE) && slot_ok && port_ok;
  assign ram_wdata = '{port: item.out_port, mask: item.prefix_mask, prefix: item.prefix};

  ipv4_lpm_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH ($bits(route_t)),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  assign take = eval_vld_r && valid_r[eval_idx_r]
             && (((ram_rdata.prefix ^ addr_r) & ram_rdata.mask) == '0)
             && ((ram_rdata.mask & best_mask_r) == best_mask_r);

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    eval_vld_nxt  = 1'b0;
    eval_idx_nxt  = eval_idx_r;
    addr_nxt      = addr_r;
    best_hit_nxt  = best_hit_r;
    best_idx_nxt  = best_idx_r;
    best_port_nxt = best_port_r;
    best_mask_nxt = best_mask_r;
    valid_nxt     = valid_r;

    if (take) begin
      best_hit_nxt  = 1'b1;
      best_idx_nxt  = eval_idx_r;
      best_port_nxt = ram_rdata.port;
      best_mask_nxt = ram_rdata.mask;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          best_hit_nxt  = 1'b0;
          best_idx_nxt  = '0;
          best_port_nxt = '0;
          best_mask_nxt = '0;
          addr_nxt      = item.lookup_addr;
          rd_idx_nxt    = '0;
          state_nxt     = ST_DONE;
          case (item.cmd)
            CMD_LOOKUP: begin
              state_nxt = ST_SCAN;
            end
            CMD_WRITE: begin
              if (slot_ok && port_ok) begin
                valid_nxt[slot] = 1'b1;
              end
            end
            CMD_INVALIDATE: begin
              if (slot_ok) begin
                valid_nxt[slot] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        eval_vld_nxt = 1'b1;
        eval_idx_nxt = rd_idx_r;
        if (rd_idx_r == LAST_IDX) begin
          state_nxt = ST_LAST;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
      ST_LAST: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      eval_vld_r <= 1'b0;
      valid_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      eval_vld_r <= eval_vld_nxt;
      valid_r    <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    eval_idx_r  <= eval_idx_nxt;
    addr_r      <= addr_nxt;
    best_hit_r  <= best_hit_nxt;
    best_idx_r  <= best_idx_nxt;
    best_port_r <= best_port_nxt;
    best_mask_r <= best_mask_nxt;
  end

  assign best_idx_ext = {{ENTRY_INDEX_W{1'b0}}, best_idx_r};

  assign item_ready = (state_r == ST_IDLE);
  assign res_valid  = (state_r == ST_DONE);
  assign res.hit         = best_hit_r;
  assign res.match_index = best_idx_ext[ENTRY_INDEX_W-1:0];
  assign res.match_port  = best_port_r;
  assign res.match_mask  = best_mask_r;

  `LPM_ASSERT_NEXT(a_lookup_starts_scan, accept && (item.cmd == CMD_LOOKUP), state_r == ST_SCAN, "lookup did not start the table scan")
  `LPM_ASSERT_NEXT(a_scan_ends, (state_r == ST_SCAN) && (rd_idx_r == LAST_IDX), (state_r == ST_LAST) && eval_vld_r, "scan did not end after the last entry")
  `LPM_ASSERT_NEXT(a_write_sets_valid, ram_we, valid_r[$past(slot)], "route write did not set its valid bit")
  `LPM_ASSERT_SAME(a_miss_is_zero, (state_r == ST_DONE) && !best_hit_r, (best_mask_r == '0) && (best_idx_r == '0) && (best_port_r == '0), "miss result is not all zero")

endmodule

FILE: hdl/ipv4_longest_prefix_route_lookup_top.sv
// Channel   Direction  tdata (low bit first)                               tuser
// in_       input      entry_index, prefix, prefix_mask, out_port, addr    cmd
// out_      output     hit, match_index, match_port, match_mask, zero pad  none
//
// A lookup reads the table entries in turn through the route RAM's single read port, and
// its result enters the output register from ST_DONE; the engine then accepts the next
// in ST_IDLE. A write or invalidate goes straight to ST_DONE; one is in work at a time.
// Reset clears the valid bits at once; the route RAM needs no clearing pass.
// A result that finds the output register full waits, and in_tready stays low meanwhile.
module ipv4_longest_prefix_route_lookup_top
  import ipv4_lpm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // entry_index, prefix, prefix_mask, out_port, lookup_addr
  input  logic [1:0]   in_tuser,  // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata  // hit, match_index, match_port, match_mask, zero fill
);

  item_t   item;
  result_t res;
  logic    res_valid;
  logic    res_ready;
  logic    out_tvalid_r, out_tvalid_nxt;
  result_t out_res_r;

  assign item.cmd         = cmd_t'(in_tuser);
  assign item.entry_index = in_tdata[3:0];
  assign item.prefix      = in_tdata[35:4];
  assign item.prefix_mask = in_tdata[67:36];
  assign item.out_port    = in_tdata[71:68];
  assign item.lookup_addr = in_tdata[103:72];

  ipv4_lpm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_ready) begin
      out_tvalid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_res_r.match_mask, out_res_r.match_port,
                       out_res_r.match_index, out_res_r.hit};

endmodule
